@@ sv/greedy_box_suppression_assert.svh @@
// Assertion macros used by the checker file of greedy_box_suppression.
// Depends on signals named clk and rst_n in the scope where a macro is used.
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/gbs_pkg.sv @@
// Package for greedy_box_suppression: sizes, stored-entry layout, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package gbs_pkg;

    localparam int MaxKept   = 64;
    localparam int SlotW     = (MaxKept > 1) ? $clog2(MaxKept) : 1;
    localparam int CountW    = $clog2(MaxKept + 1);
    localparam int KeptSlotW = 6;
    localparam int ThrW      = 9;
    localparam logic [ThrW-1:0] ThrReset = 9'd115;
    localparam int CoordW    = 16;
    localparam int SizeW     = 15;
    localparam int EdgeW     = 18;
    localparam int AreaW     = 30;
    localparam int UnionW    = 31;
    localparam int ProdW     = 40;
    localparam int PipeDepth = 6;

    typedef struct packed {
        logic [AreaW-1:0]         area;
        logic [SizeW-1:0]         height;
        logic [SizeW-1:0]         width;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] left;
    } kept_t;

    localparam int KeptW = $bits(kept_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             area_en;
        logic             issue;
        logic             write;
        logic [SlotW-1:0] addr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic busy;
    } dp_status_t;

endpackage

`default_nettype wire

@@ sv/greedy_box_suppression.sv @@
// Top level of greedy_box_suppression: stream ports, configuration port and the
// controller and datapath instances. Depends on gbs_pkg, gbs_ctrl, gbs_datapath.
`default_nettype none

// Class-agnostic greedy non-maximum suppression. Boxes arrive on the slave stream
// already sorted by falling score; each transaction carries one box and returns
// exactly one result transaction on the master stream. A box is kept unless its
// intersection over union with a box kept earlier in the same frame exceeds
// iou_threshold/256, tested without division as inter*256 > threshold*union.
// Setting tuser on an input transaction starts a new frame and empties the kept
// list first. Up to 64 boxes are kept per frame; a survivor that finds the list
// full is reported with list_full set and is not stored. Boxes are handled one at
// a time. After a box is accepted its area is computed, then the boxes in the
// kept list are read one after another through the single read port of the
// kept-box RAM; each read passes through the RAM and the five-stage overlap test
// pipeline, and once the pipeline is empty the controller decides and loads the
// result register. The slave side is ready again in the same cycle that the
// result appears on the master side. A result still waiting on the master side
// holds the decision back. The result sits in an output register, so the next box
// is accepted while the previous result still waits for the master side. The
// threshold is written through cfg_we/cfg_wdata; the user must write it only
// while no box is in flight, as the block itself does not enforce this. It
// resets to 115.

module greedy_box_suppression (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Slave stream. tdata: box_left[15:0], box_top[31:16], box_width[46:32],
    // box_height[61:47], zero padding[63:62].
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    // tuser: frame_start[0].
    input  wire logic        s_axis_tuser,
    // Master stream. tdata: kept_slot[5:0], zero padding[7:6].
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,
    // tuser: keep[0], list_full[1].
    output logic [1:0]       m_axis_tuser,
    // Configuration: iou_threshold.
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata
);

    gbs_pkg::ctrl_cmd_t            cmd;
    gbs_pkg::dp_status_t           status;
    logic                          res_keep;
    logic                          res_full;
    logic [gbs_pkg::KeptSlotW-1:0] res_slot;

    // The controller owns sequencing, the kept count and the result register.
    gbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_first  (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_keep  (res_keep),
        .out_slot  (res_slot),
        .out_full  (res_full)
    );

    // The datapath holds the candidate, the kept-box store and the overlap test.
    gbs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_left   ($signed(s_axis_tdata[15:0])),
        .in_top    ($signed(s_axis_tdata[31:16])),
        .in_width  (s_axis_tdata[46:32]),
        .in_height (s_axis_tdata[61:47]),
        .thr_we    (cfg_we),
        .thr_wdata (cfg_wdata)
    );

    // Pack the result; the slot field is zero whenever the box was not stored.
    assign m_axis_tdata = {2'b00, res_slot};
    assign m_axis_tuser = {res_full, res_keep};

endmodule

`default_nettype wire

@@ sv/gbs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies; used for the kept-box store.
`default_nettype none

module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/gbs_ctrl.sv @@
// Controller of greedy_box_suppression: state machine, kept count, scan index
// and the result register. Depends on gbs_pkg.
`default_nettype none

module gbs_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_first,
    output logic                               in_ready,
    output gbs_pkg::ctrl_cmd_t                 cmd,
    input  wire gbs_pkg::dp_status_t           status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_keep,
    output logic [gbs_pkg::KeptSlotW-1:0]      out_slot,
    output logic                               out_full
);

    gbs_pkg::state_t state_reg, state_next;
    logic [gbs_pkg::CountW-1:0]    count_reg, count_next;
    logic [gbs_pkg::CountW-1:0]    idx_reg, idx_next;
    logic                          valid_reg, valid_next;
    logic                          keep_reg, keep_next;
    logic                          full_reg, full_next;
    logic [gbs_pkg::KeptSlotW-1:0] slot_reg, slot_next;
    logic                          out_free;
    logic                          has_room;

    assign out_free = !valid_reg || out_ready;
    assign has_room = count_reg < gbs_pkg::CountW'(gbs_pkg::MaxKept);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbs_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg <= keep_next;
        full_reg <= full_next;
        slot_reg <= slot_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && !out_ready;
        keep_next   = keep_reg;
        full_next   = full_reg;
        slot_next   = slot_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.area_en = 1'b0;
        cmd.issue   = 1'b0;
        cmd.write   = 1'b0;
        cmd.addr    = idx_reg[gbs_pkg::SlotW-1:0];

        unique case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    if (in_first)
                    begin
                        count_next = '0;
                    end
                    state_next = gbs_pkg::ST_AREA;
                end
            end
            gbs_pkg::ST_AREA:
            begin
                cmd.area_en = 1'b1;
                state_next  = gbs_pkg::ST_SCAN;
            end
            gbs_pkg::ST_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = gbs_pkg::ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            gbs_pkg::ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = gbs_pkg::ST_DECIDE;
                end
            end
            gbs_pkg::ST_DECIDE:
            begin
                cmd.addr = count_reg[gbs_pkg::SlotW-1:0];
                if (out_free)
                begin
                    valid_next = 1'b1;
                    keep_next  = 1'b0;
                    full_next  = 1'b0;
                    slot_next  = '0;
                    if (!status.hit)
                    begin
                        if (has_room)
                        begin
                            cmd.write  = 1'b1;
                            keep_next  = 1'b1;
                            slot_next  = gbs_pkg::KeptSlotW'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = valid_reg;
    assign out_keep  = keep_reg;
    assign out_slot  = slot_reg;
    assign out_full  = full_reg;

endmodule

`default_nettype wire

@@ sv/gbs_datapath.sv @@
// Datapath of greedy_box_suppression: candidate registers, threshold register,
// kept-box RAM and the overlap test pipeline. Depends on gbs_pkg, gbs_ram.
`default_nettype none

module gbs_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire gbs_pkg::ctrl_cmd_t               cmd,
    output gbs_pkg::dp_status_t                   status,
    input  wire logic signed [gbs_pkg::CoordW-1:0] in_left,
    input  wire logic signed [gbs_pkg::CoordW-1:0] in_top,
    input  wire logic [gbs_pkg::SizeW-1:0]        in_width,
    input  wire logic [gbs_pkg::SizeW-1:0]        in_height,
    input  wire logic                             thr_we,
    input  wire logic [gbs_pkg::ThrW-1:0]         thr_wdata
);

    logic [gbs_pkg::ThrW-1:0]          thr_reg;
    logic signed [gbs_pkg::CoordW-1:0] left_reg, top_reg;
    logic [gbs_pkg::SizeW-1:0]         width_reg, height_reg;
    logic [gbs_pkg::AreaW-1:0]         area_reg;
    logic [gbs_pkg::PipeDepth-1:0]     vld_reg;
    logic                              hit_reg;

    gbs_pkg::kept_t                    wr_entry, rd_entry;
    logic [gbs_pkg::KeptW-1:0]         rd_word;

    logic signed [gbs_pkg::EdgeW-1:0]  cx0, cx1, cy0, cy1, kx0, kx1, ky0, ky1;
    logic signed [gbs_pkg::EdgeW-1:0]  xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic [gbs_pkg::AreaW-1:0]         ab1_reg, ab2_reg, ab3_reg;
    logic [gbs_pkg::SizeW-1:0]         iw_reg, ih_reg;
    logic [gbs_pkg::AreaW-1:0]         inter3_reg, inter4_reg, inter5_reg;
    logic [gbs_pkg::UnionW-1:0]        union_reg;
    logic                              nz_reg;
    logic [gbs_pkg::ProdW-1:0]         prod_reg;
    logic [gbs_pkg::ProdW-1:0]         inter_scaled;

    assign wr_entry.area   = area_reg;
    assign wr_entry.height = height_reg;
    assign wr_entry.width  = width_reg;
    assign wr_entry.top    = top_reg;
    assign wr_entry.left   = left_reg;

    gbs_ram #(
        .WIDTH (gbs_pkg::KeptW),
        .DEPTH (gbs_pkg::MaxKept)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (cmd.addr),
        .wdata (wr_entry),
        .raddr (cmd.addr),
        .rdata (rd_word)
    );

    assign rd_entry = gbs_pkg::kept_t'(rd_word);

    // Box edges as half-open intervals, widened so the far edge cannot overflow.
    assign cx0 = gbs_pkg::EdgeW'(left_reg);
    assign cy0 = gbs_pkg::EdgeW'(top_reg);
    assign cx1 = cx0 + $signed({3'b000, width_reg});
    assign cy1 = cy0 + $signed({3'b000, height_reg});
    assign kx0 = gbs_pkg::EdgeW'(rd_entry.left);
    assign ky0 = gbs_pkg::EdgeW'(rd_entry.top);
    assign kx1 = kx0 + $signed({3'b000, rd_entry.width});
    assign ky1 = ky0 + $signed({3'b000, rd_entry.height});

    assign inter_scaled = gbs_pkg::ProdW'({inter5_reg, 8'd0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= gbs_pkg::ThrReset;
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (thr_we)
            begin
                thr_reg <= thr_wdata;
            end
            vld_reg <= {vld_reg[gbs_pkg::PipeDepth-2:0], cmd.issue};
            if (cmd.capture)
            begin
                hit_reg <= 1'b0;
            end
            else if (vld_reg[gbs_pkg::PipeDepth-1] && nz_reg && (inter_scaled > prod_reg))
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            left_reg   <= in_left;
            top_reg    <= in_top;
            width_reg  <= in_width;
            height_reg <= in_height;
        end
        if (cmd.area_en)
        begin
            area_reg <= gbs_pkg::AreaW'(width_reg) * gbs_pkg::AreaW'(height_reg);
        end

        // Stage 1: overlap interval ends.
        xlo_reg <= (cx0 > kx0) ? cx0 : kx0;
        xhi_reg <= (cx1 < kx1) ? cx1 : kx1;
        ylo_reg <= (cy0 > ky0) ? cy0 : ky0;
        yhi_reg <= (cy1 < ky1) ? cy1 : ky1;
        ab1_reg <= rd_entry.area;

        // Stage 2: overlap lengths, zero when disjoint.
        iw_reg  <= (xhi_reg > xlo_reg) ? gbs_pkg::SizeW'(xhi_reg - xlo_reg) : '0;
        ih_reg  <= (yhi_reg > ylo_reg) ? gbs_pkg::SizeW'(yhi_reg - ylo_reg) : '0;
        ab2_reg <= ab1_reg;

        // Stage 3: intersection area.
        inter3_reg <= gbs_pkg::AreaW'(iw_reg) * gbs_pkg::AreaW'(ih_reg);
        ab3_reg    <= ab2_reg;

        // Stage 4: union area; never negative since the intersection fits in both boxes.
        union_reg  <= gbs_pkg::UnionW'(area_reg) + gbs_pkg::UnionW'(ab3_reg)
                      - gbs_pkg::UnionW'(inter3_reg);
        inter4_reg <= inter3_reg;

        // Stage 5: threshold times union.
        prod_reg   <= gbs_pkg::ProdW'(thr_reg) * gbs_pkg::ProdW'(union_reg);
        nz_reg     <= (union_reg != '0);
        inter5_reg <= inter4_reg;
    end

    assign status.hit  = hit_reg;
    assign status.busy = |vld_reg;

endmodule

`default_nettype wire

@@ sv/greedy_box_suppression_checker.sv @@
// Port-level checker for greedy_box_suppression, bound to the top level.
// Depends on greedy_box_suppression_assert.svh.
`default_nettype none

`include "greedy_box_suppression_assert.svh"

module greedy_box_suppression_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A stored box and a dropped survivor are mutually exclusive outcomes.
    `GBS_ASSERT_IMPLY(a_keep_full_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

    // The slot field is zero unless the box was stored.
    `GBS_ASSERT_IMPLY(a_slot_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0)

    // One box at a time: after an input transaction the slave side stops accepting.
    `GBS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A stalled result holds its payload.
    `GBS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind greedy_box_suppression greedy_box_suppression_checker u_checker (.*);

`default_nettype wire
